>>> rtl/core/mcf_pkg.sv
// ----------------------------------------------------------------------------
// mcf_pkg
// Shared field widths, register indexes and the sequencer state type of the
// min-cost flow solver.
// ----------------------------------------------------------------------------
package mcf_pkg;

   localparam int VTX_FIELD_W = 6;   // edge_tail, edge_head, source, sink
   localparam int CAP_W       = 16;  // edge_capacity
   localparam int COST_W      = 16;  // edge_cost
   localparam int FLOW_W      = 16;  // flow_demand, flow_reached
   localparam int TOTAL_W     = 41;  // total_cost
   localparam int VCOUNT_W    = 7;   // vertex_count
   localparam int CAPM_W      = 17;  // residual capacity entry
   localparam int COSTM_W     = 17;  // stored arc cost, exact negation
   localparam int DIST_W      = 24;  // path distance
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_ADDR_W  = 4;

   typedef enum logic [1:0] {
      CSR_VERTEX_COUNT  = 2'd0,
      CSR_SOURCE_VERTEX = 2'd1,
      CSR_SINK_VERTEX   = 2'd2,
      CSR_FLOW_DEMAND   = 2'd3
   } mcf_csr_type;

   typedef enum logic [4:0] {
      ST_CLEAR,
      ST_LOAD,
      ST_START,
      ST_LOOP,
      ST_INIT,
      ST_POP,
      ST_POP_WAIT,
      ST_DIST_WAIT,
      ST_SCAN,
      ST_SEARCH_END,
      ST_DIST_T,
      ST_BN_TEST,
      ST_BN_PAR,
      ST_BN_CAP,
      ST_BN_END,
      ST_ACC,
      ST_AUG_TEST,
      ST_AUG_PAR,
      ST_AUG_DN,
      ST_AUG_UP,
      ST_RESULT
   } mcf_state_type;

endpackage

>>> rtl/core/mcf_req_if.sv
// ----------------------------------------------------------------------------
// mcf_req_if
// Edge channel: one directed edge per beat, valid/ready handshake.
// ----------------------------------------------------------------------------
interface mcf_req_if;
   logic                                  valid;
   logic                                  ready;
   logic [mcf_pkg::VTX_FIELD_W-1:0]       edge_tail;
   logic [mcf_pkg::VTX_FIELD_W-1:0]       edge_head;
   logic [mcf_pkg::CAP_W-1:0]             edge_capacity;
   logic signed [mcf_pkg::COST_W-1:0]     edge_cost;
   logic                                  last_edge;

   modport source (output valid, edge_tail, edge_head, edge_capacity, edge_cost,
                   last_edge, input ready);
   modport sink   (input valid, edge_tail, edge_head, edge_capacity, edge_cost,
                   last_edge, output ready);
endinterface

>>> rtl/core/mcf_rsp_if.sv
// ----------------------------------------------------------------------------
// mcf_rsp_if
// Result channel: one solve result per beat, valid/ready handshake.
// ----------------------------------------------------------------------------
interface mcf_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [mcf_pkg::TOTAL_W-1:0]    total_cost;
   logic [mcf_pkg::FLOW_W-1:0]            flow_reached;
   logic                                  feasible;

   modport source (output valid, total_cost, flow_reached, feasible, input ready);
   modport sink   (input valid, total_cost, flow_reached, feasible, output ready);
endinterface

>>> rtl/core/min_cost_flow_spfa_top.sv
// ----------------------------------------------------------------------------
// min_cost_flow_spfa_top
// Min-cost flow by successive shortest paths with a queue-based search.
// ----------------------------------------------------------------------------
// Edges load at one beat per cycle into the capacity and cost matrices. The
// beat flagged last_edge starts the solve; the edge port stays stalled until
// the result is handed to the result register and both matrices are swept
// back to zero. That sweep writes one entry per cycle over all
// 2^(2*clog2(MAX_VERTICES)) entries (4096 at 64 vertices) and also runs right
// after reset. Solve time follows the graph: each queue pop scans a row of
// both matrices, n entries (n = active vertex count); a path hop takes the
// BN_TEST, BN_PAR and BN_CAP states for the bottleneck and AUG_TEST,
// AUG_PAR, AUG_DN and AUG_UP for the capacity update. The result beat may
// wait in its output register while the next problem loads.
// ----------------------------------------------------------------------------
module min_cost_flow_spfa_top #(
   parameter int MAX_VERTICES = 64
) (
   input  logic                                  clock,
   input  logic                                  reset,
   mcf_req_if.sink                               req_bus,
   mcf_rsp_if.source                             rsp_bus,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [mcf_pkg::CSR_ADDR_W-1:0]        csr_paddr,
   input  logic [mcf_pkg::CSR_DATA_W-1:0]        csr_pwdata,
   output logic [mcf_pkg::CSR_DATA_W-1:0]        csr_prdata,
   output logic                                  csr_pready
);

   localparam int VW     = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int CW     = $clog2(MAX_VERTICES + 1);
   localparam int AW     = 2 * VW;
   localparam int MDEPTH = 1 << AW;
   localparam int LW     = 2 * CW;
   localparam int FW     = mcf_pkg::FLOW_W;
   localparam int DW     = mcf_pkg::DIST_W;
   localparam int TW     = mcf_pkg::TOTAL_W;

   // ------------------------------------------------------------------------
   // configuration registers
   // ------------------------------------------------------------------------
   logic [mcf_pkg::VCOUNT_W-1:0]    vcount_ff;
   logic [mcf_pkg::VTX_FIELD_W-1:0] src_ff;
   logic [mcf_pkg::VTX_FIELD_W-1:0] snk_ff;
   logic [FW-1:0]                   demand_ff;
   logic                            csr_wr;
   mcf_pkg::mcf_csr_type            csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = mcf_pkg::mcf_csr_type'(csr_paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff <= mcf_pkg::VCOUNT_W'(64);
         src_ff    <= '0;
         snk_ff    <= mcf_pkg::VTX_FIELD_W'(1);
         demand_ff <= FW'(1);
      end else if (csr_wr) begin
         case (csr_idx)
            mcf_pkg::CSR_VERTEX_COUNT:  vcount_ff <= csr_pwdata[mcf_pkg::VCOUNT_W-1:0];
            mcf_pkg::CSR_SOURCE_VERTEX: src_ff    <= csr_pwdata[mcf_pkg::VTX_FIELD_W-1:0];
            mcf_pkg::CSR_SINK_VERTEX:   snk_ff    <= csr_pwdata[mcf_pkg::VTX_FIELD_W-1:0];
            mcf_pkg::CSR_FLOW_DEMAND:   demand_ff <= csr_pwdata[FW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         mcf_pkg::CSR_VERTEX_COUNT:  csr_prdata = mcf_pkg::CSR_DATA_W'(vcount_ff);
         mcf_pkg::CSR_SOURCE_VERTEX: csr_prdata = mcf_pkg::CSR_DATA_W'(src_ff);
         mcf_pkg::CSR_SINK_VERTEX:   csr_prdata = mcf_pkg::CSR_DATA_W'(snk_ff);
         mcf_pkg::CSR_FLOW_DEMAND:   csr_prdata = mcf_pkg::CSR_DATA_W'(demand_ff);
         default:                    csr_prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------------
   // memories
   // ------------------------------------------------------------------------
   logic [mcf_pkg::CAPM_W-1:0]         cap_mem  [MDEPTH];
   logic signed [mcf_pkg::COSTM_W-1:0] cost_mem [MDEPTH];
   logic signed [DW-1:0]               dist_mem [MAX_VERTICES];
   logic [VW-1:0]                      par_mem  [MAX_VERTICES];
   logic [VW-1:0]                      que_mem  [MAX_VERTICES];

   logic                               cap_we, cost_we, dist_we, par_we, que_we;
   logic [AW-1:0]                      cap_waddr, cap_raddr, cost_waddr, cost_raddr;
   logic [mcf_pkg::CAPM_W-1:0]         cap_wdata, cap_rd_ff;
   logic signed [mcf_pkg::COSTM_W-1:0] cost_wdata, cost_rd_ff;
   logic [VW-1:0]                      dist_waddr, dist_raddr, par_waddr, par_raddr;
   logic [VW-1:0]                      que_waddr, que_raddr;
   logic signed [DW-1:0]               dist_wdata, dist_rd_ff;
   logic [VW-1:0]                      par_wdata, par_rd_ff, que_wdata, que_rd_ff;

   always_ff @(posedge clock) begin
      if (cap_we) cap_mem[cap_waddr] <= cap_wdata;
      cap_rd_ff <= cap_mem[cap_raddr];
   end

   always_ff @(posedge clock) begin
      if (cost_we) cost_mem[cost_waddr] <= cost_wdata;
      cost_rd_ff <= cost_mem[cost_raddr];
   end

   always_ff @(posedge clock) begin
      if (dist_we) dist_mem[dist_waddr] <= dist_wdata;
      dist_rd_ff <= dist_mem[dist_raddr];
   end

   always_ff @(posedge clock) begin
      if (par_we) par_mem[par_waddr] <= par_wdata;
      par_rd_ff <= par_mem[par_raddr];
   end

   always_ff @(posedge clock) begin
      if (que_we) que_mem[que_waddr] <= que_wdata;
      que_rd_ff <= que_mem[que_raddr];
   end

   // ------------------------------------------------------------------------
   // sequencer registers
   // ------------------------------------------------------------------------
   mcf_pkg::mcf_state_type state_ff, state_in;
   logic [AW-1:0]           clr_addr_ff, clr_addr_in;
   logic [CW-1:0]           n_ff, n_in;
   logic [LW-1:0]           limit_ff, limit_in, pops_ff, pops_in;
   logic [VW-1:0]           head_ff, head_in;
   logic [CW-1:0]           cnt_ff, cnt_in;
   logic [VW-1:0]           u_ff, u_in;
   logic signed [DW-1:0]    dist_u_ff, dist_u_in, dist_t_ff, dist_t_in;
   logic [CW-1:0]           scan_v_ff, scan_v_in;
   logic                    s2_valid_ff, s2_valid_in;
   logic [VW-1:0]           s2_v_ff, s2_v_in;
   logic [MAX_VERTICES-1:0] reached_ff, reached_in, inq_ff, inq_in;
   logic [FW-1:0]           flow_ff, flow_in, f_ff, f_in;
   logic signed [TW-1:0]    cost_ff, cost_in, prod_ff, prod_in;
   logic [VW-1:0]           cur_ff, cur_in, p_ff, p_in;
   logic [CW-1:0]           steps_ff, steps_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [TW-1:0]    rsp_cost_ff, rsp_cost_in;
   logic [FW-1:0]           rsp_flow_ff, rsp_flow_in;
   logic                    rsp_feas_ff, rsp_feas_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mcf_pkg::ST_CLEAR;
         clr_addr_ff  <= '0;
         s2_valid_ff  <= 1'b0;
         reached_ff   <= '0;
         inq_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         s2_valid_ff  <= s2_valid_in;
         reached_ff   <= reached_in;
         inq_ff       <= inq_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff        <= n_in;
      limit_ff    <= limit_in;
      pops_ff     <= pops_in;
      head_ff     <= head_in;
      u_ff        <= u_in;
      dist_u_ff   <= dist_u_in;
      dist_t_ff   <= dist_t_in;
      scan_v_ff   <= scan_v_in;
      s2_v_ff     <= s2_v_in;
      flow_ff     <= flow_in;
      f_ff        <= f_in;
      cost_ff     <= cost_in;
      prod_ff     <= prod_in;
      cur_ff      <= cur_in;
      p_ff        <= p_in;
      steps_ff    <= steps_in;
      rsp_cost_ff <= rsp_cost_in;
      rsp_flow_ff <= rsp_flow_in;
      rsp_feas_ff <= rsp_feas_in;
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.total_cost   = rsp_cost_ff;
   assign rsp_bus.flow_reached = rsp_flow_ff;
   assign rsp_bus.feasible     = rsp_feas_ff;

   // ------------------------------------------------------------------------
   // shared datapath terms
   // ------------------------------------------------------------------------
   logic                  req_fire, edge_ok, end_ok, clr_done;
   logic [VW-1:0]         e_tail, e_head, s_idx, t_idx, scan_v;
   logic signed [DW-1:0]  e_cost_sx, cost_sx, nd;
   logic                  s2_fwd, relax, enq, rsp_free;
   logic [CW:0]           qpos_sum, qpos;
   logic [CW-1:0]         head_inc, n_clamp;
   logic signed [FW:0]    mul_a;
   logic signed [TW-1:0]  mul_p;

   assign req_fire  = req_bus.valid && req_bus.ready;
   assign edge_ok   = (int'(req_bus.edge_tail) < MAX_VERTICES)
                      && (int'(req_bus.edge_head) < MAX_VERTICES);
   assign e_tail    = VW'(req_bus.edge_tail);
   assign e_head    = VW'(req_bus.edge_head);
   assign e_cost_sx = DW'(req_bus.edge_cost);
   assign s_idx     = VW'(src_ff);
   assign t_idx     = VW'(snk_ff);
   assign end_ok    = (int'(src_ff) < int'(n_ff)) && (int'(snk_ff) < int'(n_ff));
   assign clr_done  = (clr_addr_ff == {AW{1'b1}});
   assign scan_v    = VW'(scan_v_ff);
   assign rsp_free  = !rsp_valid_ff || rsp_bus.ready;

   always_comb begin
      if (vcount_ff == '0) begin
         n_clamp = CW'(1);
      end else if (int'(vcount_ff) > MAX_VERTICES) begin
         n_clamp = CW'(MAX_VERTICES);
      end else begin
         n_clamp = CW'(vcount_ff);
      end
   end

   // relaxation stage: matrix row entry and distance of v were read in the previous cycle
   assign s2_fwd   = (u_ff < s2_v_ff);
   assign cost_sx  = DW'(cost_rd_ff);
   assign nd       = s2_fwd ? (dist_u_ff + cost_sx) : (dist_u_ff - cost_sx);
   assign relax    = s2_valid_ff && (s2_v_ff != u_ff) && (cap_rd_ff != '0)
                     && (!reached_ff[s2_v_ff] || (nd < dist_rd_ff));
   assign enq      = relax && !inq_ff[s2_v_ff] && (cnt_ff < n_ff);
   assign qpos_sum = (CW+1)'(head_ff) + (CW+1)'(cnt_ff);
   assign qpos     = (qpos_sum >= (CW+1)'(n_ff)) ? (qpos_sum - (CW+1)'(n_ff)) : qpos_sum;
   assign head_inc = ((CW'(head_ff) + CW'(1)) == n_ff) ? '0 : (CW'(head_ff) + CW'(1));

   assign mul_a = $signed({1'b0, f_ff});
   assign mul_p = mul_a * dist_t_ff;

   // ------------------------------------------------------------------------
   // next state
   // ------------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mcf_pkg::ST_CLEAR:      if (clr_done) state_in = mcf_pkg::ST_LOAD;
         mcf_pkg::ST_LOAD:       if (req_fire && req_bus.last_edge) state_in = mcf_pkg::ST_START;
         mcf_pkg::ST_START:      state_in = end_ok ? mcf_pkg::ST_LOOP : mcf_pkg::ST_RESULT;
         mcf_pkg::ST_LOOP:       state_in = (flow_ff < demand_ff) ? mcf_pkg::ST_INIT
                                                                  : mcf_pkg::ST_RESULT;
         mcf_pkg::ST_INIT:       state_in = mcf_pkg::ST_POP;
         mcf_pkg::ST_POP:        state_in = ((cnt_ff == '0) || (pops_ff >= limit_ff))
                                            ? mcf_pkg::ST_SEARCH_END : mcf_pkg::ST_POP_WAIT;
         mcf_pkg::ST_POP_WAIT:   state_in = mcf_pkg::ST_DIST_WAIT;
         mcf_pkg::ST_DIST_WAIT:  state_in = mcf_pkg::ST_SCAN;
         mcf_pkg::ST_SCAN:       if ((scan_v_ff == n_ff) && !s2_valid_ff) begin
            state_in = mcf_pkg::ST_POP;
         end
         mcf_pkg::ST_SEARCH_END: state_in = reached_ff[t_idx] ? mcf_pkg::ST_DIST_T
                                                              : mcf_pkg::ST_RESULT;
         mcf_pkg::ST_DIST_T:     state_in = mcf_pkg::ST_BN_TEST;
         mcf_pkg::ST_BN_TEST:    state_in = ((cur_ff != s_idx) && (steps_ff < n_ff))
                                            ? mcf_pkg::ST_BN_PAR : mcf_pkg::ST_BN_END;
         mcf_pkg::ST_BN_PAR:     state_in = mcf_pkg::ST_BN_CAP;
         mcf_pkg::ST_BN_CAP:     state_in = mcf_pkg::ST_BN_TEST;
         mcf_pkg::ST_BN_END:     state_in = ((cur_ff != s_idx) || (f_ff == '0))
                                            ? mcf_pkg::ST_RESULT : mcf_pkg::ST_ACC;
         mcf_pkg::ST_ACC:        state_in = mcf_pkg::ST_AUG_TEST;
         mcf_pkg::ST_AUG_TEST:   state_in = (cur_ff != s_idx) ? mcf_pkg::ST_AUG_PAR
                                                              : mcf_pkg::ST_LOOP;
         mcf_pkg::ST_AUG_PAR:    state_in = mcf_pkg::ST_AUG_DN;
         mcf_pkg::ST_AUG_DN:     state_in = mcf_pkg::ST_AUG_UP;
         mcf_pkg::ST_AUG_UP:     state_in = mcf_pkg::ST_AUG_TEST;
         mcf_pkg::ST_RESULT:     if (rsp_free) state_in = mcf_pkg::ST_CLEAR;
         default:                state_in = mcf_pkg::ST_CLEAR;
      endcase
   end

   // ------------------------------------------------------------------------
   // datapath and memory control
   // ------------------------------------------------------------------------
   always_comb begin
      clr_addr_in  = clr_addr_ff;
      n_in         = n_ff;
      limit_in     = limit_ff;
      pops_in      = pops_ff;
      head_in      = head_ff;
      cnt_in       = cnt_ff;
      u_in         = u_ff;
      dist_u_in    = dist_u_ff;
      dist_t_in    = dist_t_ff;
      scan_v_in    = scan_v_ff;
      s2_valid_in  = 1'b0;
      s2_v_in      = s2_v_ff;
      reached_in   = reached_ff;
      inq_in       = inq_ff;
      flow_in      = flow_ff;
      f_in         = f_ff;
      cost_in      = cost_ff;
      prod_in      = prod_ff;
      cur_in       = cur_ff;
      p_in         = p_ff;
      steps_in     = steps_ff;
      rsp_cost_in  = rsp_cost_ff;
      rsp_flow_in  = rsp_flow_ff;
      rsp_feas_in  = rsp_feas_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      req_bus.ready = 1'b0;

      cap_we = 1'b0;  cap_waddr = '0;  cap_wdata = '0;  cap_raddr = '0;
      cost_we = 1'b0; cost_waddr = '0; cost_wdata = '0; cost_raddr = '0;
      dist_we = 1'b0; dist_waddr = '0; dist_wdata = '0; dist_raddr = '0;
      par_we = 1'b0;  par_waddr = '0;  par_wdata = '0;  par_raddr = '0;
      que_we = 1'b0;  que_waddr = '0;  que_wdata = '0;  que_raddr = '0;

      case (state_ff)
         mcf_pkg::ST_CLEAR: begin
            cap_we      = 1'b1;
            cap_waddr   = clr_addr_ff;
            cost_we     = 1'b1;
            cost_waddr  = clr_addr_ff;
            clr_addr_in = clr_addr_ff + AW'(1);
         end
         mcf_pkg::ST_LOAD: begin
            req_bus.ready = 1'b1;
            n_in          = n_clamp;
            if (req_fire && edge_ok) begin
               cap_we    = 1'b1;
               cap_waddr = {e_tail, e_head};
               cap_wdata = mcf_pkg::CAPM_W'(req_bus.edge_capacity);
               // one cost entry per vertex pair, kept for the low-to-high direction
               cost_we   = 1'b1;
               if (e_tail < e_head) begin
                  cost_waddr = {e_tail, e_head};
                  cost_wdata = mcf_pkg::COSTM_W'(e_cost_sx);
               end else begin
                  cost_waddr = {e_head, e_tail};
                  cost_wdata = -mcf_pkg::COSTM_W'(e_cost_sx);
               end
            end
         end
         mcf_pkg::ST_START: begin
            limit_in = LW'(n_ff) * LW'(n_ff);
            flow_in  = '0;
            cost_in  = '0;
         end
         mcf_pkg::ST_INIT: begin
            reached_in        = '0;
            reached_in[s_idx] = 1'b1;
            inq_in            = '0;
            inq_in[s_idx]     = 1'b1;
            dist_we           = 1'b1;
            dist_waddr        = s_idx;
            dist_wdata        = '0;
            que_we            = 1'b1;
            que_waddr         = '0;
            que_wdata         = s_idx;
            head_in           = '0;
            cnt_in            = CW'(1);
            pops_in           = '0;
         end
         mcf_pkg::ST_POP: begin
            if ((cnt_ff != '0) && (pops_ff < limit_ff)) begin
               que_raddr = head_ff;
               head_in   = VW'(head_inc);
               cnt_in    = cnt_ff - CW'(1);
               pops_in   = pops_ff + LW'(1);
            end
         end
         mcf_pkg::ST_POP_WAIT: begin
            u_in              = que_rd_ff;
            dist_raddr        = que_rd_ff;
            inq_in[que_rd_ff] = 1'b0;
         end
         mcf_pkg::ST_DIST_WAIT: begin
            dist_u_in = dist_rd_ff;
            scan_v_in = '0;
         end
         mcf_pkg::ST_SCAN: begin
            // issue the next row entry
            if (scan_v_ff != n_ff) begin
               cap_raddr   = {u_ff, scan_v};
               cost_raddr  = (u_ff < scan_v) ? {u_ff, scan_v} : {scan_v, u_ff};
               dist_raddr  = scan_v;
               s2_valid_in = 1'b1;
               s2_v_in     = scan_v;
               scan_v_in   = scan_v_ff + CW'(1);
            end
            // relax the entry read last cycle
            if (relax) begin
               dist_we             = 1'b1;
               dist_waddr          = s2_v_ff;
               dist_wdata          = nd;
               par_we              = 1'b1;
               par_waddr           = s2_v_ff;
               par_wdata           = u_ff;
               reached_in[s2_v_ff] = 1'b1;
            end
            if (enq) begin
               inq_in[s2_v_ff] = 1'b1;
               que_we          = 1'b1;
               que_waddr       = VW'(qpos);
               que_wdata       = s2_v_ff;
               cnt_in          = cnt_ff + CW'(1);
            end
         end
         mcf_pkg::ST_SEARCH_END: begin
            f_in       = demand_ff - flow_ff;
            cur_in     = t_idx;
            steps_in   = '0;
            dist_raddr = t_idx;
         end
         mcf_pkg::ST_DIST_T: begin
            dist_t_in = dist_rd_ff;
         end
         mcf_pkg::ST_BN_TEST: begin
            par_raddr = cur_ff;
         end
         mcf_pkg::ST_BN_PAR: begin
            p_in      = par_rd_ff;
            cap_raddr = {par_rd_ff, cur_ff};
         end
         mcf_pkg::ST_BN_CAP: begin
            if (cap_rd_ff < mcf_pkg::CAPM_W'(f_ff)) f_in = cap_rd_ff[FW-1:0];
            cur_in   = p_ff;
            steps_in = steps_ff + CW'(1);
         end
         mcf_pkg::ST_BN_END: begin
            if ((cur_ff == s_idx) && (f_ff != '0)) begin
               flow_in = flow_ff + f_ff;
               prod_in = mul_p;
               cur_in  = t_idx;
            end
         end
         mcf_pkg::ST_ACC: begin
            cost_in = cost_ff + prod_ff;
         end
         mcf_pkg::ST_AUG_TEST: begin
            par_raddr = cur_ff;
         end
         mcf_pkg::ST_AUG_PAR: begin
            p_in      = par_rd_ff;
            cap_raddr = {par_rd_ff, cur_ff};
         end
         mcf_pkg::ST_AUG_DN: begin
            cap_we    = 1'b1;
            cap_waddr = {p_ff, cur_ff};
            cap_wdata = cap_rd_ff - mcf_pkg::CAPM_W'(f_ff);
            cap_raddr = {cur_ff, p_ff};
         end
         mcf_pkg::ST_AUG_UP: begin
            cap_we    = 1'b1;
            cap_waddr = {cur_ff, p_ff};
            cap_wdata = cap_rd_ff + mcf_pkg::CAPM_W'(f_ff);
            cur_in    = p_ff;
         end
         mcf_pkg::ST_RESULT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_feas_in  = (flow_ff >= demand_ff);
               rsp_cost_in  = (flow_ff >= demand_ff) ? cost_ff : '0;
               rsp_flow_in  = flow_ff;
               clr_addr_in  = '0;
            end
         end
         default: ;
      endcase
   end

   // ------------------------------------------------------------------------
   // checks
   // ------------------------------------------------------------------------
   a_queue_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mcf_pkg::ST_POP) |-> ($countones(inq_ff) == int'(cnt_ff)))
      else $error("queue count disagrees with in-queue flags");

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mcf_pkg::ST_SCAN) |-> (cnt_ff <= n_ff))
      else $error("work queue overfilled");

   a_stage_in_scan: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff |-> (state_ff == mcf_pkg::ST_SCAN))
      else $error("relax stage active outside a row scan");

   a_push_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mcf_pkg::ST_ACC) |-> (f_ff != '0))
      else $error("augmenting with zero bottleneck");

   a_clear_after_result: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> (state_ff == mcf_pkg::ST_CLEAR))
      else $error("result issued without matrix sweep");

endmodule
